/* rtl/brc_pkg.sv */
// shared constants, types and record layout for the bitmap request combiner
`timescale 1ns / 1ps

package brc_pkg;

	localparam int NUM_SOURCES      = 8;
	localparam int SLOTS_PER_SOURCE = 4;
	localparam int NUM_RECORDS      = NUM_SOURCES * SLOTS_PER_SOURCE;
	localparam int MAX_RESULTS      = 32;

	localparam int SRC_IW  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int SLOT_IW = $clog2(SLOTS_PER_SOURCE);
	localparam int REC_IW  = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
	localparam int PRIO_W  = (NUM_SOURCES > SLOTS_PER_SOURCE) ? NUM_SOURCES : SLOTS_PER_SOURCE;
	localparam int PRIO_IW = (PRIO_W > 1) ? $clog2(PRIO_W) : 1;
	localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		KIND_ACCEPT  = 3'd0,
		KIND_BUSY    = 3'd1,
		KIND_SERVED  = 3'd2,
		KIND_UNKNOWN = 3'd3,
		KIND_EMPTY   = 3'd4
	} result_kind_t;

	typedef struct packed {
		logic [63:0] deadline;
		logic [5:0]  target;
		logic        unknown;
		logic        valid;
	} rec_t;

	typedef struct packed {
		logic              en;
		logic [REC_IW-1:0] addr;
		rec_t              data;
	} rec_wr_t;

endpackage

/* rtl/brc_prio_enc.sv */
// shared highest-set-bit search unit, used for both source and slot lookup
`timescale 1ns / 1ps

module brc_prio_enc
	import brc_pkg::*;
(
	input  logic [PRIO_W-1:0]  vec,
	output logic               found,
	output logic [PRIO_IW-1:0] idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = 0; i < PRIO_W; i++) begin
			if (vec[i]) begin
				found = 1'b1;
				idx   = PRIO_IW'(i);
			end
		end
	end

endmodule

/* rtl/brc_rec_mem.sv */
// record store: one write port, one registered read port
`timescale 1ns / 1ps

module brc_rec_mem
	import brc_pkg::*;
(
	input  logic              clk,
	input  rec_wr_t           wr,
	input  logic [REC_IW-1:0] raddr,
	output rec_t              rdata
);

	rec_t mem [NUM_RECORDS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bitmap_request_combiner.sv */
// top level: publish bitmaps, combine sequencer and result registers
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------------------
//  command   | start in, busy out      | cmd, src_cpu, req_kind, arg_cpu, arg_deadline,
//            |                         | arg_valid
//  result    | strobe out (no stall)   | result_kind, out_source, out_slot, out_target,
//            |                         | out_deadline, out_valid, last
//
//  a publish is answered at once: its result shows in the cycle after the accept edge and a
//  new transaction can be accepted right away
//  a combine serves each record by source search, then slot search plus record read, then
//  emit, a walk set by the single shared search unit and the registered record read
//  a pending source with no busy slots costs an extra source search; nothing pending ends there
//  arst_n clears the bitmaps, ring pointers and sequencer; record contents are not reset
//  results are never stalled: each is on the ports for exactly one cycle with strobe
`timescale 1ns / 1ps

module bitmap_request_combiner
	import brc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [2:0]  src_cpu,
	input  logic        req_kind,
	input  logic [5:0]  arg_cpu,
	input  logic [63:0] arg_deadline,
	input  logic        arg_valid,
	output logic        strobe,
	output logic [2:0]  result_kind,
	output logic [2:0]  out_source,
	output logic [1:0]  out_slot,
	output logic [5:0]  out_target,
	output logic [63:0] out_deadline,
	output logic        out_valid,
	output logic        last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRC,
		S_SLOT,
		S_EMIT
	} state_t;

	state_t state_q;

	// bitmaps and ring pointers
	logic [SLOTS_PER_SOURCE-1:0] busy_q    [NUM_SOURCES];
	logic [SLOT_IW-1:0]          nslot_q   [NUM_SOURCES];
	logic [NUM_SOURCES-1:0]      pending_q;

	// combine walk
	logic [SRC_IW-1:0]  src_q;
	logic [SLOT_IW-1:0] slot_q;
	logic [CNT_W-1:0]   cnt_q;

	// result registers
	logic         strobe_q;
	result_kind_t kind_q;
	logic [2:0]   source_q;
	logic [1:0]   oslot_q;
	logic [5:0]   target_q;
	logic [63:0]  deadline_q;
	logic         valid_q;
	logic         last_q;

	// shared search unit
	logic [PRIO_W-1:0]  prio_vec;
	logic               prio_found;
	logic [PRIO_IW-1:0] prio_idx;
	logic [SRC_IW-1:0]  prio_src;
	logic [SLOT_IW-1:0] prio_slot;

	// record store
	rec_wr_t           mem_wr;
	logic [REC_IW-1:0] mem_raddr;
	rec_t              mem_rdata;

	// publish decode
	logic [SRC_IW-1:0]  pub_src;
	logic               pub_oor;
	logic [SLOT_IW-1:0] pub_slot;
	logic               pub_hit;
	logic               accept;

	logic [NUM_SOURCES-1:0] busy_or;
	logic                   more_left;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// a source index beyond the configured count is rejected
	assign pub_oor  = (32'(src_cpu) >= 32'(NUM_SOURCES));
	assign pub_src  = SRC_IW'(src_cpu);
	assign pub_slot = nslot_q[pub_src];
	assign pub_hit  = busy_q[pub_src][pub_slot];

	always_comb begin
		for (int s = 0; s < NUM_SOURCES; s++) begin
			busy_or[s] = |busy_q[s];
		end
	end

	// anything still drainable once the current record is cleared
	assign more_left = |(pending_q & busy_or);

	// search unit looks at the pending vector, or at one source's busy slots
	always_comb begin
		if (state_q == S_SLOT) begin
			prio_vec = PRIO_W'(busy_q[src_q]);
		end else begin
			prio_vec = PRIO_W'(pending_q);
		end
	end

	brc_prio_enc u_prio (
		.vec   (prio_vec),
		.found (prio_found),
		.idx   (prio_idx)
	);

	assign prio_src  = SRC_IW'(prio_idx);
	assign prio_slot = SLOT_IW'(prio_idx);

	// record write on an accepted publish into a free slot
	always_comb begin
		mem_wr.en            = accept && !cmd && !pub_oor && !pub_hit;
		mem_wr.addr          = REC_IW'(pub_src) * REC_IW'(SLOTS_PER_SOURCE) + REC_IW'(pub_slot);
		mem_wr.data.deadline = arg_deadline;
		mem_wr.data.target   = arg_cpu;
		mem_wr.data.unknown  = req_kind;
		mem_wr.data.valid    = arg_valid;
	end

	assign mem_raddr = REC_IW'(src_q) * REC_IW'(SLOTS_PER_SOURCE) + REC_IW'(prio_slot);

	brc_rec_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pending_q <= '0;
			for (int s = 0; s < NUM_SOURCES; s++) begin
				busy_q[s]  <= '0;
				nslot_q[s] <= '0;
			end
			src_q    <= '0;
			slot_q   <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && !cmd) begin
						// publish: answered at once
						strobe_q   <= 1'b1;
						source_q   <= src_cpu;
						target_q   <= '0;
						deadline_q <= '0;
						valid_q    <= 1'b0;
						last_q     <= 1'b1;
						if (pub_oor) begin
							kind_q  <= KIND_BUSY;
							oslot_q <= '0;
						end else if (pub_hit) begin
							kind_q  <= KIND_BUSY;
							oslot_q <= 2'(pub_slot);
						end else begin
							kind_q                    <= KIND_ACCEPT;
							oslot_q                   <= 2'(pub_slot);
							busy_q[pub_src][pub_slot] <= 1'b1;
							pending_q[pub_src]        <= 1'b1;
							if (32'(pub_slot) == 32'(SLOTS_PER_SOURCE - 1)) begin
								nslot_q[pub_src] <= '0;
							end else begin
								nslot_q[pub_src] <= pub_slot + SLOT_IW'(1);
							end
						end
					end else if (accept) begin
						cnt_q   <= '0;
						state_q <= S_SRC;
					end
				end
				S_SRC: begin
					if (!prio_found) begin
						// only reached on a combine that found nothing at all
						strobe_q   <= 1'b1;
						kind_q     <= KIND_EMPTY;
						source_q   <= '0;
						oslot_q    <= '0;
						target_q   <= '0;
						deadline_q <= '0;
						valid_q    <= 1'b0;
						last_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (!busy_or[prio_src]) begin
						// stale pending bit, drop it silently
						pending_q[prio_src] <= 1'b0;
					end else begin
						src_q   <= prio_src;
						state_q <= S_SLOT;
					end
				end
				S_SLOT: begin
					// record read launched this cycle, clear its busy bit now
					slot_q                  <= prio_slot;
					busy_q[src_q][prio_slot] <= 1'b0;
					if (busy_q[src_q] == (SLOTS_PER_SOURCE'(1) << prio_slot)) begin
						pending_q[src_q] <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					strobe_q <= 1'b1;
					source_q <= 3'(src_q);
					oslot_q  <= 2'(slot_q);
					if (mem_rdata.unknown) begin
						kind_q     <= KIND_UNKNOWN;
						target_q   <= '0;
						deadline_q <= '0;
						valid_q    <= 1'b0;
					end else begin
						kind_q     <= KIND_SERVED;
						target_q   <= mem_rdata.target;
						deadline_q <= mem_rdata.deadline;
						valid_q    <= mem_rdata.valid;
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (!more_left || (cnt_q == CNT_W'(MAX_RESULTS - 1))) begin
						last_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						last_q  <= 1'b0;
						state_q <= S_SRC;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe       = strobe_q;
	assign result_kind  = kind_q;
	assign out_source   = source_q;
	assign out_slot     = oslot_q;
	assign out_target   = target_q;
	assign out_deadline = deadline_q;
	assign out_valid    = valid_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	// a result without last means the walk is still going
	a_nonlast_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |-> busy)
		else $error("non-final result while sequencer idle");

	// nothing-pending answer is always the final one
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (kind_q == KIND_EMPTY) |-> last_q)
		else $error("empty result without last");

	// a publish answers in the next cycle with a single final result
	a_publish_answer: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cmd |=> strobe_q && last_q && !busy)
		else $error("publish not answered in one cycle");

	// between transactions a source is pending exactly when it holds busy slots
	a_pending_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pending_q == busy_or))
		else $error("pending bitmap out of step with busy bitmaps");
`endif

endmodule

/* tb/sv/tb_bitmap_request_combiner.sv */
// self-checking testbench for the bitmap request combiner: publish and combine traffic
`timescale 1ns / 1ps

module tb_bitmap_request_combiner;
	import brc_pkg::*;

	// no accepted transaction and no result for this long means the block is stuck
	localparam int WATCHDOG_CYCLES = 2000;
	// quiet cycles after the last result, enough for a few stray strobes to show up
	localparam int SETTLE_CYCLES   = 16;

	typedef enum logic {
		CMD_PUBLISH = 1'b0,
		CMD_COMBINE = 1'b1
	} cmd_t;

	typedef enum logic {
		REQ_SET     = 1'b0,
		REQ_UNKNOWN = 1'b1
	} req_kind_t;

	// one result transaction, laid out in the order of the result ports
	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  source;
		logic [1:0]  slot;
		logic [5:0]  target;
		logic [63:0] deadline;
		logic        valid;
		logic        last;
	} outcome_t;

	// mirror of the publication bitmaps plus the queue of results still owed by the block
	class combiner_scoreboard;
		logic [SLOTS_PER_SOURCE-1:0] slot_map[NUM_SOURCES];
		logic [NUM_SOURCES-1:0]      src_pending;
		logic [SLOT_IW-1:0]          ring_ptr[NUM_SOURCES];
		rec_t                        records[NUM_RECORDS];
		outcome_t                    awaited_q[$];
		int errors;
		int n_taken;
		int n_bounced;
		int n_served;
		int n_unknown;
		int n_empty;
		int widest_drain;

		function new();
			foreach (slot_map[i]) begin
				slot_map[i] = '0;
				ring_ptr[i] = '0;
			end
			src_pending  = '0;
			errors       = 0;
			n_taken      = 0;
			n_bounced    = 0;
			n_served     = 0;
			n_unknown    = 0;
			n_empty      = 0;
			widest_drain = 0;
		endfunction

		function int top_bit(logic [63:0] v);
			for (int i = 63; i >= 0; i--)
				if (v[i])
					return i;
			return -1;
		endfunction

		function int outstanding();
			return awaited_q.size();
		endfunction

		// an accepted command transaction: update the mirror and queue what it must produce
		function void note_command(cmd_t c, logic [2:0] src, req_kind_t k, logic [5:0] tgt,
			logic [63:0] dl, logic v);
			outcome_t o;
			outcome_t batch[$];
			int s;
			int b;
			int r;
			o = '0;
			if (c == CMD_PUBLISH) begin
				o.source = src;
				o.slot   = ring_ptr[src];
				o.last   = 1'b1;
				if (slot_map[src][ring_ptr[src]]) begin
					o.kind = KIND_BUSY;
					n_bounced++;
				end else begin
					r = int'(src) * SLOTS_PER_SOURCE + int'(ring_ptr[src]);
					records[r].deadline = dl;
					records[r].target   = tgt;
					records[r].unknown  = (k == REQ_UNKNOWN);
					records[r].valid    = v;
					slot_map[src][ring_ptr[src]] = 1'b1;
					src_pending[src] = 1'b1;
					ring_ptr[src]    = ring_ptr[src] + SLOT_IW'(1);
					o.kind = KIND_ACCEPT;
					n_taken++;
				end
				awaited_q.push_back(o);
				return;
			end
			while (batch.size() < MAX_RESULTS && src_pending != '0) begin
				s = top_bit(64'(src_pending));
				if (slot_map[s] == '0) begin
					src_pending[s] = 1'b0;
					continue;
				end
				b = top_bit(64'(slot_map[s]));
				r = s * SLOTS_PER_SOURCE + b;
				o = '0;
				o.source = 3'(s);
				o.slot   = 2'(b);
				if (records[r].unknown) begin
					o.kind = KIND_UNKNOWN;
					n_unknown++;
				end else begin
					o.kind     = KIND_SERVED;
					o.target   = records[r].target;
					o.deadline = records[r].deadline;
					o.valid    = records[r].valid;
					n_served++;
				end
				batch.push_back(o);
				slot_map[s][b] = 1'b0;
				if (slot_map[s] == '0)
					src_pending[s] = 1'b0;
			end
			if (batch.size() == 0) begin
				o = '0;
				o.kind = KIND_EMPTY;
				batch.push_back(o);
				n_empty++;
			end
			if (batch.size() > widest_drain)
				widest_drain = batch.size();
			o = batch.pop_back();
			o.last = 1'b1;
			batch.push_back(o);
			foreach (batch[i])
				awaited_q.push_back(batch[i]);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		// a result transaction seen on the ports, checked against the oldest one owed
		function void check_result(outcome_t got);
			outcome_t want;
			if (awaited_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0h", $time, got);
				return;
			end
			want = awaited_q.pop_front();
			compare("result_kind", 64'(want.kind), 64'(got.kind));
			compare("out_source", 64'(want.source), 64'(got.source));
			compare("out_slot", 64'(want.slot), 64'(got.slot));
			compare("out_target", 64'(want.target), 64'(got.target));
			compare("out_deadline", want.deadline, got.deadline);
			compare("out_valid", 64'(want.valid), 64'(got.valid));
			compare("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cmd;
	logic [2:0]  src_cpu;
	logic        req_kind;
	logic [5:0]  arg_cpu;
	logic [63:0] arg_deadline;
	logic        arg_valid;
	logic        strobe;
	logic [2:0]  result_kind;
	logic [2:0]  out_source;
	logic [1:0]  out_slot;
	logic [5:0]  out_target;
	logic [63:0] out_deadline;
	logic        out_valid;
	logic        last;

	combiner_scoreboard board = new();
	int items_sent = 0;
	int idle_cycles = 0;

	bitmap_request_combiner dut (.*);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// results cannot be held off, so every strobe at a rising edge is a result transaction
	always @(posedge clk) begin
		if (arst_n && strobe)
			board.check_result({result_kind, out_source, out_slot, out_target, out_deadline,
				out_valid, last});
	end

	// watchdog: any accepted command or result restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("tb: failure");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// present one command from a falling edge and hold it until the block takes it;
	// returns at the falling edge after the accepting rising edge
	task automatic issue(cmd_t c, logic [2:0] src, req_kind_t k, logic [5:0] tgt,
		logic [63:0] dl, logic v);
		start        = 1'b1;
		cmd          = c;
		src_cpu      = src;
		req_kind     = k;
		arg_cpu      = tgt;
		arg_deadline = dl;
		arg_valid    = v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		board.note_command(c, src, k, tgt, dl, v);
		items_sent++;
		@(negedge clk);
	endtask

	// publish with random content, mostly set operations and now and then an unknown kind
	task automatic publish(logic [2:0] src);
		issue(CMD_PUBLISH, src, ($urandom_range(0, 99) < 15) ? REQ_UNKNOWN : REQ_SET,
			6'($urandom), {$urandom, $urandom}, 1'($urandom));
	endtask

	// combine ignores the payload, so it carries junk to prove that
	task automatic combine();
		issue(CMD_COMBINE, 3'($urandom), req_kind_t'($urandom_range(0, 1)), 6'($urandom),
			{$urandom, $urandom}, 1'($urandom));
	endtask

	// sender gap, taken with a chance of pct percent, with start low and junk on the payload
	task automatic pause(int pct);
		int gap;
		if ($urandom_range(0, 99) < pct) begin
			gap          = $urandom_range(1, 6);
			start        = 1'b0;
			cmd          = 1'($urandom);
			src_cpu      = 3'($urandom);
			arg_deadline = {$urandom, $urandom};
			repeat (gap) @(negedge clk);
		end
	endtask

	// hold the sender off until the block owes nothing
	task automatic drain_results();
		start = 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);
	endtask

	// one phase of random traffic at a given sender idle rate
	task automatic run_phase(int idle_pct, int quota);
		int first;
		int roll;
		logic [2:0] hot;
		first = items_sent;
		hot   = 3'($urandom);
		// fill every slot of every source, bounce one more, then drain all 32 in one combine
		for (int round = 0; round < SLOTS_PER_SOURCE; round++)
			for (int s = NUM_SOURCES - 1; s >= 0; s--) begin
				publish(3'(s));
				pause(idle_pct);
			end
		publish(3'($urandom));
		pause(idle_pct);
		combine();
		pause(idle_pct);
		// mixed traffic; one source gets most publishes so its ring fills and bounces
		while (items_sent - first < quota) begin
			roll = $urandom_range(0, 99);
			if (roll < 12)
				combine();
			else if (roll < 55)
				publish(hot);
			else
				publish(3'($urandom));
			pause(idle_pct);
		end
		// let everything owed arrive, then leave the bitmaps empty for the next phase
		drain_results();
		combine();
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_PUBLISH;
		src_cpu      = '0;
		req_kind     = REQ_SET;
		arg_cpu      = '0;
		arg_deadline = '0;
		arg_valid    = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: combine with nothing pending right after reset
		combine();
		// field extremes, all zero and all one
		issue(CMD_PUBLISH, 3'd0, REQ_SET, 6'd0, 64'd0, 1'b0);
		issue(CMD_PUBLISH, 3'd7, REQ_SET, 6'd63, '1, 1'b1);
		// unknown kind record: drained later as an error with zeroed arguments
		issue(CMD_PUBLISH, 3'd7, REQ_UNKNOWN, 6'd63, '1, 1'b1);
		issue(CMD_PUBLISH, 3'd7, REQ_SET, 6'h2a, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
		issue(CMD_PUBLISH, 3'd7, REQ_SET, 6'h15, 64'h5555_5555_5555_5555, 1'b0);
		// ring of source 7 is full: the next publish is bounced on slot 0
		issue(CMD_PUBLISH, 3'd7, REQ_SET, 6'd1, 64'd1, 1'b1);
		issue(CMD_PUBLISH, 3'd3, REQ_SET, 6'h2a, 64'h5555_5555_5555_5555, 1'b1);
		issue(CMD_PUBLISH, 3'd3, REQ_UNKNOWN, 6'h15, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		// drain order: source 7 slots 3..0, source 3 slots 1..0, source 0 slot 0
		combine();
		combine();
		// ring pointer of source 7 has wrapped back to slot 0
		issue(CMD_PUBLISH, 3'd7, REQ_SET, 6'd9, 64'h8000_0000_0000_0001, 1'b1);
		combine();

		// random traffic: busy sender, mostly idle sender, back to back
		run_phase(22, 100);
		run_phase(61, 100);
		run_phase(0, 100);

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d commands: %0d publishes taken, %0d bounced on a busy slot",
			items_sent, board.n_taken, board.n_bounced);
		$display("drained %0d records and %0d unknown-kind errors, %0d empty combines, largest %0d",
			board.n_served, board.n_unknown, board.n_empty, board.widest_drain);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
